// ===== design/bqn_pkg.sv =====
package bqn_pkg;

    // Fixed formats: Q2.30-style coefficients and Q24.8 delay words.
    localparam int COEF_W    = 32;
    localparam int DELAY_W   = 32;
    localparam int DELAY_FRAC = 8;
    localparam int PROD_W    = COEF_W + DELAY_W;
    // Room for three full products plus the rounding bias.
    localparam int ACC_W     = PROD_W + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ON  = 3'd5;

    localparam logic [COEF_W-1:0] B0_RESET = 32'h4000_0000;

    typedef enum logic [2:0] {
        MUL_D1_A1 = 3'd0,
        MUL_D2_A2 = 3'd1,
        MUL_W_B0  = 3'd2,
        MUL_D1_B1 = 3'd3,
        MUL_D2_B2 = 3'd4
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD    = 3'd0,
        ACC_BIAS_FB = 3'd1,
        ACC_BIAS_FF = 3'd2,
        ACC_ADD     = 3'd3,
        ACC_SUB     = 3'd4
    } acc_op_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     w_calc;
        logic     out_load;
    } cmd_t;

endpackage

// ===== design/bqn_ctrl.sv =====
module bqn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic          filter_on,
    output bqn_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_FB_D1  = 10'b00_0000_0010,
        ST_FB_D2  = 10'b00_0000_0100,
        ST_FB_ACC = 10'b00_0000_1000,
        ST_W_CALC = 10'b00_0001_0000,
        ST_FF_W   = 10'b00_0010_0000,
        ST_FF_D1  = 10'b00_0100_0000,
        ST_FF_D2  = 10'b00_1000_0000,
        ST_FF_ACC = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign take      = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.accept     = 1'b0;
        cmd.mul_sel    = bqn_pkg::MUL_D1_A1;
        cmd.acc_op     = bqn_pkg::ACC_HOLD;
        cmd.w_calc     = 1'b0;
        cmd.out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.accept = 1'b1;
                    cmd.acc_op = bqn_pkg::ACC_BIAS_FB;
                    state_next = filter_on ? ST_FB_D1 : ST_DONE;
                end
            end
            ST_FB_D1:
            begin
                cmd.mul_sel = bqn_pkg::MUL_D1_A1;
                state_next  = ST_FB_D2;
            end
            ST_FB_D2:
            begin
                cmd.mul_sel = bqn_pkg::MUL_D2_A2;
                cmd.acc_op  = bqn_pkg::ACC_SUB;
                state_next  = ST_FB_ACC;
            end
            ST_FB_ACC:
            begin
                cmd.acc_op = bqn_pkg::ACC_SUB;
                state_next = ST_W_CALC;
            end
            ST_W_CALC:
            begin
                cmd.w_calc = 1'b1;
                cmd.acc_op = bqn_pkg::ACC_BIAS_FF;
                state_next = ST_FF_W;
            end
            ST_FF_W:
            begin
                cmd.mul_sel = bqn_pkg::MUL_W_B0;
                state_next  = ST_FF_D1;
            end
            ST_FF_D1:
            begin
                cmd.mul_sel = bqn_pkg::MUL_D1_B1;
                cmd.acc_op  = bqn_pkg::ACC_ADD;
                state_next  = ST_FF_D2;
            end
            ST_FF_D2:
            begin
                cmd.mul_sel = bqn_pkg::MUL_D2_B2;
                cmd.acc_op  = bqn_pkg::ACC_ADD;
                state_next  = ST_FF_ACC;
            end
            ST_FF_ACC:
            begin
                cmd.acc_op = bqn_pkg::ACC_ADD;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here until the output register can take the word.
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/bqn_datapath.sv =====
module bqn_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bqn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bqn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  bqn_pkg::cmd_t                       cmd,
    output logic                                filter_on,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                clipped
);

    localparam int AW = bqn_pkg::ACC_W;
    localparam int DW = bqn_pkg::DELAY_W;
    localparam int CW = bqn_pkg::COEF_W;
    localparam int PW = bqn_pkg::PROD_W;

    localparam logic signed [AW-1:0] FB_BIAS = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] FF_BIAS =
        AW'(1) << (COEF_FRAC_BITS + bqn_pkg::DELAY_FRAC - 1);
    localparam logic signed [AW-1:0] W_MAX = (AW'(1) << (DW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] W_MIN = ~W_MAX;
    localparam logic signed [AW-1:0] Y_MAX = (AW'(1) << (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;

    logic signed [CW-1:0]          b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                          on_reg;
    logic                          primed_reg;
    logic signed [DW-1:0]          d1_reg, d2_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          pass_reg;
    logic signed [DW-1:0]          w_reg;
    logic                          hit_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [AW-1:0]          acc_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          clipped_reg;

    logic signed [DW-1:0]          op_a;
    logic signed [CW-1:0]          op_b;
    logic signed [AW-1:0]          prod_wide;
    logic signed [AW-1:0]          w_full;
    logic signed [DW-1:0]          w_sat;
    logic                          w_hit;
    logic signed [AW-1:0]          y_full;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_hit;

    assign filter_on  = on_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= bqn_pkg::B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
            on_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bqn_pkg::CFG_B0: b0_reg <= cfg_data;
                bqn_pkg::CFG_B1: b1_reg <= cfg_data;
                bqn_pkg::CFG_B2: b2_reg <= cfg_data;
                bqn_pkg::CFG_A1: a1_reg <= cfg_data;
                bqn_pkg::CFG_A2: a2_reg <= cfg_data;
                bqn_pkg::CFG_ON: on_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand select.
    always_comb
    begin
        op_a = d1_reg;
        op_b = a1_reg;
        case (cmd.mul_sel)
            bqn_pkg::MUL_D1_A1: begin op_a = d1_reg; op_b = a1_reg; end
            bqn_pkg::MUL_D2_A2: begin op_a = d2_reg; op_b = a2_reg; end
            bqn_pkg::MUL_W_B0:  begin op_a = w_reg;  op_b = b0_reg; end
            bqn_pkg::MUL_D1_B1: begin op_a = d1_reg; op_b = b1_reg; end
            bqn_pkg::MUL_D2_B2: begin op_a = d2_reg; op_b = b2_reg; end
            default: ;
        endcase
    end

    assign prod_wide = AW'(prod_reg);

    // New delay word: rounded feedback plus the scaled sample, saturated.
    always_comb
    begin
        w_full = (AW'(x_reg) <<< bqn_pkg::DELAY_FRAC) + (acc_reg >>> COEF_FRAC_BITS);
        w_hit  = 1'b0;
        w_sat  = w_full[DW-1:0];
        if (w_full > W_MAX)
        begin
            w_sat = W_MAX[DW-1:0];
            w_hit = 1'b1;
        end
        else if (w_full < W_MIN)
        begin
            w_sat = W_MIN[DW-1:0];
            w_hit = 1'b1;
        end
    end

    // Output sample: bias was preloaded, so only the shift and clamp remain.
    always_comb
    begin
        y_full = acc_reg >>> (COEF_FRAC_BITS + bqn_pkg::DELAY_FRAC);
        y_hit  = 1'b0;
        y_sat  = y_full[SAMPLE_BITS-1:0];
        if (y_full > Y_MAX)
        begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
            y_hit = 1'b1;
        end
        else if (y_full < Y_MIN)
        begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
            y_hit = 1'b1;
        end
    end

    // Filter state: delays and the armed flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg     <= '0;
            d2_reg     <= '0;
            primed_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (!on_reg)
            begin
                primed_reg <= 1'b0;
            end
            else if (!primed_reg)
            begin
                d1_reg     <= '0;
                d2_reg     <= '0;
                primed_reg <= 1'b1;
            end
        end
        else if (cmd.out_load && !pass_reg)
        begin
            d2_reg <= d1_reg;
            d1_reg <= w_reg;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (cmd.accept)
        begin
            x_reg    <= sample_in;
            pass_reg <= !on_reg;
        end
        if (cmd.w_calc)
        begin
            w_reg   <= w_sat;
            hit_reg <= w_hit;
        end
        case (cmd.acc_op)
            bqn_pkg::ACC_BIAS_FB: acc_reg <= FB_BIAS;
            bqn_pkg::ACC_BIAS_FF: acc_reg <= FF_BIAS;
            bqn_pkg::ACC_ADD:     acc_reg <= acc_reg + prod_wide;
            bqn_pkg::ACC_SUB:     acc_reg <= acc_reg - prod_wide;
            default: ;
        endcase
        if (cmd.out_load)
        begin
            if (pass_reg)
            begin
                sample_out_reg <= x_reg;
                clipped_reg    <= 1'b0;
            end
            else
            begin
                sample_out_reg <= y_sat;
                clipped_reg    <= hit_reg | y_hit;
            end
        end
    end

endmodule

// ===== design/biquad_notch_filter.sv =====
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------
// input     in_valid / in_stall   sample_in
// output    out_valid / out_stall sample_out, clipped
// config    cfg_write             cfg_index, cfg_data (no handshake)
//
// A filtered word runs through the feedback, delay-word and feedforward steps
// (one shared 32x32 multiplier, five products, one per cycle); a pass-through
// word (filter off) goes straight to the final step. in_stall is high until
// the result moves to the output register, so no new word is taken while one
// is in flight; a stalled output holds the block in its final step.
// Reset restores the coefficients (b0 = 1.0), disarms and clears the delays.
module biquad_notch_filter #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration writes, taken on any cycle with cfg_write high.
    input  logic                               cfg_write,
    input  logic [bqn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bqn_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input sample words.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      sample_in,
    // Result words.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               clipped
);

    bqn_pkg::cmd_t cmd;
    logic          filter_on;

    // Sequence the multiply-accumulate steps and own the handshakes.
    bqn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filter_on (filter_on),
        .cmd       (cmd)
    );

    // Coefficients, delay line, multiplier, accumulator and output register.
    bqn_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cmd        (cmd),
        .filter_on  (filter_on),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule

// ===== verif/biquad_notch_filter_tb.sv =====
typedef logic signed [95:0] wide_t;
typedef logic signed [23:0] sample_t;

// Tracks the filter state and coefficients and holds the expected output words.
class biquad_shadow;
    logic signed [31:0] b0, b1, b2, a1, a2;
    logic               on;
    logic               primed;
    logic signed [31:0] d1, d2;
    int                 frac;

    sample_t            want_sample[$];
    logic               want_clip[$];

    int taken, filtered, checked, clip_count, errors;

    function new(int coef_frac);
        frac = coef_frac;
        b0 = bqn_pkg::B0_RESET;
        b1 = '0;
        b2 = '0;
        a1 = '0;
        a2 = '0;
        on = 1'b0;
        primed = 1'b0;
        d1 = '0;
        d2 = '0;
    endfunction

    function void write_reg(logic [bqn_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            bqn_pkg::CFG_B0: b0 = data;
            bqn_pkg::CFG_B1: b1 = data;
            bqn_pkg::CFG_B2: b2 = data;
            bqn_pkg::CFG_A1: a1 = data;
            bqn_pkg::CFG_A2: a2 = data;
            bqn_pkg::CFG_ON: on = data[0];
            default: ;
        endcase
    endfunction

    function wide_t prod(logic signed [31:0] x, logic signed [31:0] y);
        wide_t ex, ey;
        ex = x;
        ey = y;
        return ex * ey;
    endfunction

    function wide_t clamp(wide_t v, int bits);
        wide_t top;
        top = (wide_t'(1) <<< (bits - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function void take_sample(sample_t x);
        wide_t ex, fb, ff, w_full, w_sat, y_full, y_sat;
        logic  clip;
        taken++;
        if (!on) begin
            primed = 1'b0;
            want_sample.push_back(x);
            want_clip.push_back(1'b0);
            return;
        end
        if (!primed) begin
            d1 = '0;
            d2 = '0;
            primed = 1'b1;
        end
        ex = x;
        fb = -prod(d1, a1) - prod(d2, a2);
        w_full = (ex <<< bqn_pkg::DELAY_FRAC)
               + ((fb + (wide_t'(1) <<< (frac - 1))) >>> frac);
        w_sat = clamp(w_full, 32);
        ff = prod(w_sat[31:0], b0) + prod(d1, b1) + prod(d2, b2);
        y_full = (ff + (wide_t'(1) <<< (frac + bqn_pkg::DELAY_FRAC - 1)))
               >>> (frac + bqn_pkg::DELAY_FRAC);
        y_sat = clamp(y_full, $bits(sample_t));
        clip = (w_sat != w_full) || (y_sat != y_full);
        d2 = d1;
        d1 = w_sat[31:0];
        want_sample.push_back(y_sat[$bits(sample_t)-1:0]);
        want_clip.push_back(clip);
        filtered++;
        if (clip)
            clip_count++;
    endfunction

    function void check_word(sample_t got_sample, logic got_clip);
        sample_t exp_sample;
        logic    exp_clip;
        if (want_sample.size() == 0) begin
            $error("unexpected output word: sample_out=%0d clipped=%b", got_sample, got_clip);
            errors++;
            return;
        end
        exp_sample = want_sample.pop_front();
        exp_clip = want_clip.pop_front();
        checked++;
        if (got_sample !== exp_sample) begin
            $error("sample_out: expected %0d, actual %0d", exp_sample, got_sample);
            errors++;
        end
        if (got_clip !== exp_clip) begin
            $error("clipped: expected %b, actual %b", exp_clip, got_clip);
            errors++;
        end
    endfunction

    function int outstanding();
        return want_sample.size();
    endfunction
endclass

module biquad_notch_filter_tb;
    import bqn_pkg::*;

    localparam int SAMPLE_W    = $bits(sample_t);
    localparam int COEF_FRAC   = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 670;

    // Indexes past the last register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam sample_t SAMPLE_MAX = 24'sh7F_FFFF;
    localparam sample_t SAMPLE_MIN = 24'sh80_0000;

    localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h8000_0000;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    sample_t               sample_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    sample_t               sample_out;
    logic                  clipped;

    biquad_shadow shadow;
    int tx_idle = 0;
    int rx_idle = 0;
    int cycle_count = 0;
    int settings = 0;

    biquad_notch_filter #(
        .SAMPLE_BITS    (SAMPLE_W),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: count edges and give up at the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d words still expected",
               cycle_count, shadow.outstanding());
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: stall at random with the current idle percentage.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
    end

    // All inputs change only just after a rising edge, so the falling edge
    // sees exactly the values the next rising edge will take. Compare any
    // output word that is about to be accepted there.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.check_word(sample_out, clipped);
    end

    // Drive one register write; cfg_write stays high so back-to-back writes
    // need no drop in between. The caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        shadow.write_reg(idx, data);
    endtask

    task automatic program_filter(input logic [31:0] b0, b1, b2, a1, a2, on_word);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_ON, on_word);
        cfg_write <= 1'b0;
        settings++;
    endtask

    // Offer one sample word, idling first at random. Returns on the edge
    // that accepts the word, with valid still high.
    task automatic send_word(input sample_t x);
        while ($urandom_range(0, 99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        shadow.take_sample(x);
        @(posedge clk);
    endtask

    // Drop valid and hold off until every expected word is back, then let
    // the block come to rest before any register write.
    task automatic settle();
        in_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Pick a new register setting. Stable filters most often, so the delays carry
    // real history; also raw random and corner coefficients, and plain
    // enable toggles that leave the coefficients alone.
    task automatic random_setting();
        logic [31:0]        c[5];
        logic [31:0]        corner[5];
        logic [31:0]        on_word;
        logic signed [31:0] rnd;
        longint             a2v, lim, a1v;
        int                 pick;
        corner = '{COEF_MIN, COEF_MAX, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000};
        pick = $urandom_range(0, 99);
        on_word = $urandom;
        on_word[0] = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
        if (pick < 15) begin
            write_reg(CFG_ON, on_word);
            cfg_write <= 1'b0;
            settings++;
            return;
        end
        if (pick < 55) begin
            // Poles inside the unit circle: |a2| < 1 and |a1| < 1 + a2.
            a2v = longint'($urandom_range(0, 2040109466)) - 64'sd1020054733;
            lim = 64'sd1073741823 + a2v;
            a1v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            c[3] = a1v[31:0];
            c[4] = a2v[31:0];
            for (int k = 0; k < 3; k++) begin
                rnd = $urandom;
                c[k] = rnd >>> $urandom_range(1, 4);
            end
        end
        else if (pick < 75) begin
            for (int k = 0; k < 5; k++)
                c[k] = $urandom;
        end
        else begin
            for (int k = 0; k < 5; k++)
                c[k] = corner[$urandom_range(0, 4)];
        end
        program_filter(c[0], c[1], c[2], c[3], c[4], on_word);
    endtask

    initial
    begin
        logic signed [31:0] rnd;
        int                 n;
        int                 shift;
        int                 target;

        shadow = new(COEF_FRAC);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: filter off, words pass straight through.
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        send_word('0);
        settle();

        // Arm with the reset coefficients (b0 = 1.0); only bit 0 of the
        // enable word counts.
        write_reg(CFG_ON, 32'hFFFF_FFFF);
        cfg_write <= 1'b0;
        settings++;
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        send_word(-24'sd1);
        settle();

        // Corner coefficients and full-scale input: drive both the delay
        // and the output into saturation.
        program_filter(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 32'h0000_0001);
        repeat (3) send_word(SAMPLE_MAX);
        repeat (3) send_word(SAMPLE_MIN);
        settle();

        // Enable word with bit 0 clear: pass through and disarm.
        write_reg(CFG_ON, 32'hFFFF_FFFE);
        cfg_write <= 1'b0;
        settings++;
        send_word(24'sd12345);
        settle();

        // Writes past the last register, then a real notch; the first word
        // after disarm must start from cleared delays.
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        program_filter(32'd1052266988, -32'sd1932735283, 32'd1052266988,
                       -32'sd1932735283, 32'd1030792151, 32'h0000_0001);
        repeat (5) begin
            rnd = $urandom;
            send_word(sample_t'(rnd >>> 8));
        end
        settle();

        // Toggle the enable with no word in between: still armed, so the
        // delays carry over.
        write_reg(CFG_ON, 32'h0000_0000);
        write_reg(CFG_ON, 32'h0000_0001);
        cfg_write <= 1'b0;
        settings++;
        repeat (2) begin
            rnd = $urandom;
            send_word(sample_t'(rnd >>> 12));
        end
        settle();

        // Random part in three idle patterns: sender light / receiver heavy,
        // the reverse, then full rate on both sides.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle = 28; rx_idle = 63; end
                1: begin tx_idle = 63; rx_idle = 28; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            target = shadow.taken + PHASE_WORDS;
            while (shadow.taken < target) begin
                random_setting();
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(8, 60);
                // Full-scale input in part of the settings, else quiet signals that keep
                // the filter out of saturation.
                shift = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
                repeat (n) begin
                    rnd = $urandom;
                    send_word(sample_t'(rnd >>> (8 + shift)));
                end
                settle();
            end
        end
        tx_idle = 0;
        rx_idle = 0;
        repeat (12) @(posedge clk);

        if (shadow.outstanding() != 0) begin
            $error("%0d expected words never arrived", shadow.outstanding());
            shadow.errors++;
        end
        $display("Summary: %0d samples sent (%0d filtered, %0d passed through) over %0d settings.",
                 shadow.taken, shadow.filtered, shadow.taken - shadow.filtered, settings);
        $display("Summary: %0d output words compared, %0d of them flagged as saturated.",
                 shadow.checked, shadow.clip_count);
        if (shadow.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/bqn_pkg.sv
design/bqn_ctrl.sv
design/bqn_datapath.sv
design/biquad_notch_filter.sv
verif/biquad_notch_filter_tb.sv
